[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/gcev_pkg.sv]
package gcev_pkg;

  localparam int NUM_BUTTONS = 10;
  localparam int STICK_BITS  = 8;

  localparam int THR_W      = 8;
  localparam int HOLD_W     = 16;
  localparam int IDX_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int CMP_W      = (STICK_BITS > THR_W) ? STICK_BITS : THR_W;

  localparam int PAD_DOWN  = 4;
  localparam int PAD_LEFT  = 5;
  localparam int PAD_RIGHT = 6;
  localparam int PAD_UP    = 7;

  localparam logic [THR_W-1:0]  UPPER_RST = THR_W'(153);
  localparam logic [THR_W-1:0]  LOWER_RST = THR_W'(103);
  localparam logic [HOLD_W-1:0] HOLD_RST  = HOLD_W'(1000);

  localparam logic [CFG_IDX_W-1:0] CFG_UPPER = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD  = CFG_IDX_W'(2);

  typedef logic [NUM_BUTTONS-1:0] btn_t;
  typedef logic [STICK_BITS-1:0]  stick_t;

  typedef struct packed {
    logic change;
    logic press;
  } lane_out_t;

  typedef struct packed {
    logic valid;
    btn_t diff;
    btn_t now;
  } stage_t;

  function automatic logic is_pad(input int i);
    return (i == PAD_DOWN) || (i == PAD_LEFT) || (i == PAD_RIGHT) || (i == PAD_UP);
  endfunction

endpackage

[design/gcev_if.sv]
interface gcev_poll_if;
  logic                  valid;
  logic                  ready;
  logic                  read_ok;
  gcev_pkg::btn_t        button_bits;
  gcev_pkg::stick_t      stick_x;
  gcev_pkg::stick_t      stick_y;
  modport source (output valid, read_ok, button_bits, stick_x, stick_y, input ready);
  modport sink (input valid, read_ok, button_bits, stick_x, stick_y, output ready);
endinterface

interface gcev_evt_if;
  logic                          valid;
  logic                          ready;
  logic [gcev_pkg::IDX_W-1:0]    button_index;
  logic                          is_press;
  logic                          is_last;
  modport source (output valid, button_index, is_press, is_last, input ready);
  modport sink (input valid, button_index, is_press, is_last, output ready);
endinterface

interface gcev_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [gcev_pkg::CFG_IDX_W-1:0]    index;
  logic [gcev_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[design/gcev_lane.sv]
module gcev_lane (
  input  logic                btn,
  input  logic                sub,
  input  logic                prev,
  output gcev_pkg::lane_out_t res
);

  logic cur;

  always_comb begin
    cur        = btn | sub;
    res.change = cur ^ prev;
    res.press  = cur;
  end

endmodule

[design/gcev_merge.sv]
module gcev_merge (
  input  logic                 clk,
  input  logic                 rst,
  input  gcev_pkg::stage_t     stg,
  output logic                 take,
  gcev_evt_if.source           evt
);

  gcev_pkg::btn_t              mask;
  gcev_pkg::btn_t              now_r;
  gcev_pkg::btn_t              rest;
  gcev_pkg::btn_t              first;
  logic [gcev_pkg::IDX_W-1:0]  pick;
  logic                        last;
  logic                        beat;

  always_comb begin
    pick = '0;
    for (int i = gcev_pkg::NUM_BUTTONS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        pick = gcev_pkg::IDX_W'(i);
      end
    end
    rest  = mask & (mask - gcev_pkg::NUM_BUTTONS'(1));
    first = mask & ~rest;
    last  = (rest == '0);
  end

  assign evt.valid        = (mask != '0);
  assign evt.button_index = pick;
  assign evt.is_press     = |(now_r & first);
  assign evt.is_last      = last;

  assign beat = evt.valid && evt.ready;
  assign take = (mask == '0) || (beat && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (beat && !last) begin
      mask <= rest;
    end else if (take) begin
      mask <= stg.valid ? stg.diff : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && stg.valid) begin
      now_r <= stg.now;
    end
  end

endmodule

[design/gamepad_change_event_generator.sv]
// channel | dir | beat contents
// poll    | in  | read_ok, button_bits, stick_x, stick_y
// evt     | out | button_index, is_press, is_last
// cfg     | in  | index, data (register write)
//
// A poll's holdoff, stick mapping and change mask are resolved at acceptance. With the
// emitter idle its first event is valid once the mask has passed the stage register and
// the emitter's mask register; events leave one per cycle while evt.ready is high.
// One stage entry sits in front of the emitter: poll.ready drops while that entry is full
// and the emitter has not sent its last beat. Synchronous reset restores registers and
// state. cfg is always ready.

`include "assert_macros.svh"

module gamepad_change_event_generator (
  input  logic         clk,
  input  logic         rst,
  gcev_poll_if.sink    poll,
  gcev_evt_if.source   evt,
  gcev_cfg_if.sink     cfg
);

  logic [gcev_pkg::THR_W-1:0]   upper;
  logic [gcev_pkg::THR_W-1:0]   lower;
  logic [gcev_pkg::HOLD_W-1:0]  err_hold;
  logic [gcev_pkg::HOLD_W-1:0]  holdoff;
  logic [gcev_pkg::HOLD_W-1:0]  holdoff_next;
  gcev_pkg::btn_t               prev;
  gcev_pkg::btn_t               prev_next;
  gcev_pkg::btn_t               now_v;
  gcev_pkg::btn_t               diff_v;
  gcev_pkg::btn_t               sub_v;
  gcev_pkg::stage_t             stg;
  gcev_pkg::stage_t             stg_next;
  gcev_pkg::lane_out_t          lane_res [gcev_pkg::NUM_BUTTONS];

  logic [gcev_pkg::CMP_W-1:0]   sx;
  logic [gcev_pkg::CMP_W-1:0]   sy;
  logic [gcev_pkg::CMP_W-1:0]   up_x;
  logic [gcev_pkg::CMP_W-1:0]   lo_x;
  logic                         go_right;
  logic                         go_left;
  logic                         go_up;
  logic                         go_down;
  logic                         pad_any;
  logic                         poll_acc;
  logic                         take;
  logic                         produce;

  assign cfg.ready  = 1'b1;
  assign poll.ready = !stg.valid || take;
  assign poll_acc   = poll.valid && poll.ready;

  // stick decode
  always_comb begin
    sx       = gcev_pkg::CMP_W'(poll.stick_x);
    sy       = gcev_pkg::CMP_W'(poll.stick_y);
    up_x     = gcev_pkg::CMP_W'(upper);
    lo_x     = gcev_pkg::CMP_W'(lower);
    go_right = sx > up_x;
    go_left  = !go_right && (sx < lo_x);
    go_up    = sy > up_x;
    go_down  = !go_up && (sy < lo_x);
    pad_any  = 1'b0;
    for (int i = 0; i < gcev_pkg::NUM_BUTTONS; i++) begin
      if (gcev_pkg::is_pad(i) && poll.button_bits[i]) begin
        pad_any = 1'b1;
      end
    end
  end

  for (genvar g = 0; g < gcev_pkg::NUM_BUTTONS; g++) begin : g_lane
    if (g == gcev_pkg::PAD_RIGHT) begin : g_r
      assign sub_v[g] = !pad_any && go_right;
    end else if (g == gcev_pkg::PAD_LEFT) begin : g_l
      assign sub_v[g] = !pad_any && go_left;
    end else if (g == gcev_pkg::PAD_UP) begin : g_u
      assign sub_v[g] = !pad_any && go_up;
    end else if (g == gcev_pkg::PAD_DOWN) begin : g_d
      assign sub_v[g] = !pad_any && go_down;
    end else begin : g_n
      assign sub_v[g] = 1'b0;
    end

    gcev_lane u_lane (
      .btn  (poll.button_bits[g]),
      .sub  (sub_v[g]),
      .prev (prev[g]),
      .res  (lane_res[g])
    );

    assign now_v[g]  = lane_res[g].press;
    assign diff_v[g] = lane_res[g].change;
  end

  always_comb begin
    holdoff_next = holdoff;
    prev_next    = prev;
    produce      = 1'b0;
    if (poll_acc) begin
      if (holdoff != '0) begin
        holdoff_next = holdoff - gcev_pkg::HOLD_W'(1);
      end else if (!poll.read_ok) begin
        holdoff_next = err_hold;
      end else begin
        prev_next = now_v;
        produce   = (diff_v != '0);
      end
    end
    stg_next.valid = (stg.valid && !take) || produce;
    stg_next.diff  = produce ? diff_v : stg.diff;
    stg_next.now   = produce ? now_v : stg.now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upper    <= gcev_pkg::UPPER_RST;
      lower    <= gcev_pkg::LOWER_RST;
      err_hold <= gcev_pkg::HOLD_RST;
      holdoff  <= '0;
      prev     <= '0;
      stg      <= '0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          gcev_pkg::CFG_UPPER: upper    <= cfg.data[gcev_pkg::THR_W-1:0];
          gcev_pkg::CFG_LOWER: lower    <= cfg.data[gcev_pkg::THR_W-1:0];
          gcev_pkg::CFG_HOLD:  err_hold <= cfg.data[gcev_pkg::HOLD_W-1:0];
          default: ;
        endcase
      end
      holdoff <= holdoff_next;
      prev    <= prev_next;
      stg     <= stg_next;
    end
  end

  gcev_merge u_merge (
    .clk  (clk),
    .rst  (rst),
    .stg  (stg),
    .take (take),
    .evt  (evt)
  );

  `CHK_NEXT(a_hold_dec, poll_acc && holdoff != '0,
    holdoff == $past(holdoff) - gcev_pkg::HOLD_W'(1), "holdoff did not count down")
  `CHK_NEXT(a_hold_load, poll_acc && holdoff == '0 && !poll.read_ok && !cfg.valid,
    holdoff == $past(err_hold), "failed read did not load holdoff")
  `CHK_NOW(a_stage_hold, stg.valid && !take, !poll.ready,
    "poll taken while stage is blocked")
  `CHK_NEXT(a_prev_keep, poll_acc && holdoff != '0, prev == $past(prev),
    "dropped poll changed previous buttons")

endmodule
